// ----- design/sit_pkg.sv -----
// ----------------------------------------------------------------------------
// sit_pkg: shared constants and types for the segment intersection test
// Coordinate width, derived datapath widths, bus widths and pipeline depth.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

	// coordinate format
	localparam int COORD_WIDTH = 16;
	localparam int W           = COORD_WIDTH;

	// differences of two coordinates
	localparam int DIFF_W = W + 1;
	// products and sums of products (den, sn, tn), signed
	localparam int PROD_W = 2 * W + 2;
	// magnitude of den and tn after sign normalization
	localparam int MAG_W  = 2 * W + 1;
	// scaled numerator tn * |r|
	localparam int NUM_W  = MAG_W + W;

	// stream bus widths, fields packed from bit 0 and padded to bytes
	localparam int IN_FIELDS  = 8;
	localparam int IN_DATA_W  = ((IN_FIELDS * W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * W + 7) / 8) * 8;

	// pipeline: five front stages, one divider stage per quotient bit, output stage
	localparam int FRONT_STAGES = 5;
	localparam int DIV_STAGES   = W;
	localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES + 1;

	// state of one item inside the divider pipeline
	typedef struct packed {
		logic                hit;
		logic [MAG_W-1:0]    den;
		logic [MAG_W-1:0]    rem_x;
		logic [MAG_W-1:0]    rem_y;
		logic [W-1:0]        low_x;
		logic [W-1:0]        low_y;
		logic [W-1:0]        quo_x;
		logic [W-1:0]        quo_y;
		logic                neg_x;
		logic                neg_y;
		logic [W-1:0]        base_x;
		logic [W-1:0]        base_y;
	} div_t;

endpackage

`default_nettype wire

// ----- design/sit_div_step.sv -----
// ----------------------------------------------------------------------------
// sit_div_step: one restoring division step
// Shifts the next numerator bit into the remainder, subtracts the divisor
// when it fits and shifts the resulting quotient bit in.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_div_step (
	input  logic [sit_pkg::MAG_W-1:0] den,
	input  logic [sit_pkg::MAG_W-1:0] rem_in,
	input  logic [sit_pkg::W-1:0]     low_in,
	input  logic [sit_pkg::W-1:0]     quo_in,
	output logic [sit_pkg::MAG_W-1:0] rem_out,
	output logic [sit_pkg::W-1:0]     low_out,
	output logic [sit_pkg::W-1:0]     quo_out
);

	logic [sit_pkg::MAG_W:0] trial;
	logic [sit_pkg::MAG_W:0] diff;
	logic                    fits;

	// remainder stays below den, so the trial value fits one extra bit
	assign trial = {rem_in, low_in[sit_pkg::W-1]};
	assign diff  = trial - {1'b0, den};
	assign fits  = trial >= {1'b0, den};

	assign rem_out = fits ? diff[sit_pkg::MAG_W-1:0] : trial[sit_pkg::MAG_W-1:0];
	assign low_out = {low_in[sit_pkg::W-2:0], 1'b0};
	assign quo_out = {quo_in[sit_pkg::W-2:0], fits};

endmodule

`default_nettype wire

// ----- design/segment_intersection_test.sv -----
// ----------------------------------------------------------------------------
// segment_intersection_test: exact 2D segment/segment intersection
// Streams pairs of segments in, streams hit flag and crossing point out.
// ----------------------------------------------------------------------------
// One segment pair enters per clock unless back-pressure from the output
// stalls the pipeline. The divider resolves one quotient bit per pipeline
// stage for x and y in parallel, after five front stages (input differences,
// cross products, den/sn/tn sums, sign normalization and hit test, numerator
// scaling) and before one output stage. Each stage holds its item until the
// next stage frees up, so back-pressure on the output squeezes out bubbles
// before s_tready drops. Parallel, collinear and degenerate segments report
// no hit; the point is zero whenever hit is low.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_test (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
	input  logic [sit_pkg::IN_DATA_W-1:0]    s_tdata,
	// output stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// cross_x, cross_y
	output logic [sit_pkg::OUT_DATA_W-1:0]   m_tdata,
	// hit
	output logic                             m_tuser
);

	localparam int W    = sit_pkg::W;
	localparam int NS   = sit_pkg::NUM_STAGES;
	localparam int DS   = sit_pkg::DIV_STAGES;
	localparam int FS   = sit_pkg::FRONT_STAGES;

	// ------------------------------------------------------------------
	// stage control: a stage loads when it is empty or its successor loads
	// ------------------------------------------------------------------
	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	always_comb begin
		en[NS-1] = ~vld_q[NS-1] | m_tready;
		for (int i = NS - 2; i >= 0; i--) begin
			en[i] = ~vld_q[i] | en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NS-1];

	// ------------------------------------------------------------------
	// input fields
	// ------------------------------------------------------------------
	logic signed [W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

	assign ax0 = s_tdata[0*W +: W];
	assign ay0 = s_tdata[1*W +: W];
	assign ax1 = s_tdata[2*W +: W];
	assign ay1 = s_tdata[3*W +: W];
	assign bx0 = s_tdata[4*W +: W];
	assign by0 = s_tdata[5*W +: W];
	assign bx1 = s_tdata[6*W +: W];
	assign by1 = s_tdata[7*W +: W];

	// ------------------------------------------------------------------
	// stage 1: direction vectors r, q and offset w
	// ------------------------------------------------------------------
	logic signed [sit_pkg::DIFF_W-1:0] rx_s1, ry_s1, qx_s1, qy_s1, wx_s1, wy_s1;
	logic        [W-1:0]               bx_s1, by_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rx_s1 <= {ax1[W-1], ax1} - {ax0[W-1], ax0};
			ry_s1 <= {ay1[W-1], ay1} - {ay0[W-1], ay0};
			qx_s1 <= {bx1[W-1], bx1} - {bx0[W-1], bx0};
			qy_s1 <= {by1[W-1], by1} - {by0[W-1], by0};
			wx_s1 <= {ax0[W-1], ax0} - {bx0[W-1], bx0};
			wy_s1 <= {ay0[W-1], ay0} - {by0[W-1], by0};
			bx_s1 <= ax0;
			by_s1 <= ay0;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: the six cross-product terms
	// ------------------------------------------------------------------
	logic signed [sit_pkg::PROD_W-1:0] rxqy_s2, qxry_s2, rxwy_s2, rywx_s2, qxwy_s2, qywx_s2;
	logic signed [sit_pkg::DIFF_W-1:0] rx_s2, ry_s2;
	logic        [W-1:0]               bx_s2, by_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			rxqy_s2 <= sit_pkg::PROD_W'(rx_s1) * sit_pkg::PROD_W'(qy_s1);
			qxry_s2 <= sit_pkg::PROD_W'(qx_s1) * sit_pkg::PROD_W'(ry_s1);
			rxwy_s2 <= sit_pkg::PROD_W'(rx_s1) * sit_pkg::PROD_W'(wy_s1);
			rywx_s2 <= sit_pkg::PROD_W'(ry_s1) * sit_pkg::PROD_W'(wx_s1);
			qxwy_s2 <= sit_pkg::PROD_W'(qx_s1) * sit_pkg::PROD_W'(wy_s1);
			qywx_s2 <= sit_pkg::PROD_W'(qy_s1) * sit_pkg::PROD_W'(wx_s1);
			rx_s2   <= rx_s1;
			ry_s2   <= ry_s1;
			bx_s2   <= bx_s1;
			by_s2   <= by_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: den, sn, tn
	// ------------------------------------------------------------------
	logic signed [sit_pkg::PROD_W-1:0] den_s3, sn_s3, tn_s3;
	logic signed [sit_pkg::DIFF_W-1:0] rx_s3, ry_s3;
	logic        [W-1:0]               bx_s3, by_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			den_s3 <= rxqy_s2 - qxry_s2;
			sn_s3  <= rxwy_s2 - rywx_s2;
			tn_s3  <= qxwy_s2 - qywx_s2;
			rx_s3  <= rx_s2;
			ry_s3  <= ry_s2;
			bx_s3  <= bx_s2;
			by_s3  <= by_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: sign normalization, inclusive range test, |r|
	// ------------------------------------------------------------------
	logic signed [sit_pkg::PROD_W-1:0] den_n, sn_n, tn_n;
	logic signed [sit_pkg::DIFF_W-1:0] rx_abs, ry_abs;
	logic                              hit_n;

	always_comb begin
		den_n  = den_s3[sit_pkg::PROD_W-1] ? -den_s3 : den_s3;
		sn_n   = den_s3[sit_pkg::PROD_W-1] ? -sn_s3  : sn_s3;
		tn_n   = den_s3[sit_pkg::PROD_W-1] ? -tn_s3  : tn_s3;
		rx_abs = rx_s3[sit_pkg::DIFF_W-1] ? -rx_s3 : rx_s3;
		ry_abs = ry_s3[sit_pkg::DIFF_W-1] ? -ry_s3 : ry_s3;
		hit_n  = (den_n != '0) && !sn_n[sit_pkg::PROD_W-1] && (sn_n <= den_n)
			&& !tn_n[sit_pkg::PROD_W-1] && (tn_n <= den_n);
	end

	logic                     hit_s4;
	logic [sit_pkg::MAG_W-1:0] den_s4, tn_s4;
	logic [W-1:0]             magx_s4, magy_s4;
	logic                     negx_s4, negy_s4;
	logic [W-1:0]             bx_s4, by_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			hit_s4  <= hit_n;
			den_s4  <= den_n[sit_pkg::MAG_W-1:0];
			tn_s4   <= tn_n[sit_pkg::MAG_W-1:0];
			magx_s4 <= rx_abs[W-1:0];
			magy_s4 <= ry_abs[W-1:0];
			negx_s4 <= rx_s3[sit_pkg::DIFF_W-1];
			negy_s4 <= ry_s3[sit_pkg::DIFF_W-1];
			bx_s4   <= bx_s3;
			by_s4   <= by_s3;
		end
	end

	// ------------------------------------------------------------------
	// stage 5: scaled numerators tn * |r|
	// ------------------------------------------------------------------
	logic                      hit_s5;
	logic [sit_pkg::MAG_W-1:0] den_s5;
	logic [sit_pkg::NUM_W-1:0] numx_s5, numy_s5;
	logic                      negx_s5, negy_s5;
	logic [W-1:0]              bx_s5, by_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			hit_s5  <= hit_s4;
			den_s5  <= den_s4;
			numx_s5 <= sit_pkg::NUM_W'(tn_s4) * sit_pkg::NUM_W'(magx_s4);
			numy_s5 <= sit_pkg::NUM_W'(tn_s4) * sit_pkg::NUM_W'(magy_s4);
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;
			bx_s5   <= bx_s4;
			by_s5   <= by_s4;
		end
	end

	// ------------------------------------------------------------------
	// divider stages: one quotient bit of x and of y per stage
	// quotient <= |r| < 2^W, so the upper numerator bits start below den
	// ------------------------------------------------------------------
	sit_pkg::div_t div_in [DS];
	sit_pkg::div_t div_sd [DS];

	always_comb begin
		div_in[0].hit    = hit_s5;
		div_in[0].den    = den_s5;
		div_in[0].rem_x  = numx_s5[sit_pkg::NUM_W-1:W];
		div_in[0].rem_y  = numy_s5[sit_pkg::NUM_W-1:W];
		div_in[0].low_x  = numx_s5[W-1:0];
		div_in[0].low_y  = numy_s5[W-1:0];
		div_in[0].quo_x  = '0;
		div_in[0].quo_y  = '0;
		div_in[0].neg_x  = negx_s5;
		div_in[0].neg_y  = negy_s5;
		div_in[0].base_x = bx_s5;
		div_in[0].base_y = by_s5;
		for (int k = 1; k < DS; k++) begin
			div_in[k] = div_sd[k-1];
		end
	end

	for (genvar k = 0; k < DS; k++) begin : g_div
		sit_pkg::div_t nxt;

		always_comb begin
			nxt.hit    = div_in[k].hit;
			nxt.den    = div_in[k].den;
			nxt.neg_x  = div_in[k].neg_x;
			nxt.neg_y  = div_in[k].neg_y;
			nxt.base_x = div_in[k].base_x;
			nxt.base_y = div_in[k].base_y;
		end

		sit_div_step u_step_x (
			.den     (div_in[k].den),
			.rem_in  (div_in[k].rem_x),
			.low_in  (div_in[k].low_x),
			.quo_in  (div_in[k].quo_x),
			.rem_out (nxt.rem_x),
			.low_out (nxt.low_x),
			.quo_out (nxt.quo_x)
		);

		sit_div_step u_step_y (
			.den     (div_in[k].den),
			.rem_in  (div_in[k].rem_y),
			.low_in  (div_in[k].low_y),
			.quo_in  (div_in[k].quo_y),
			.rem_out (nxt.rem_y),
			.low_out (nxt.low_y),
			.quo_out (nxt.quo_y)
		);

		always_ff @(posedge clk) begin
			if (en[FS + k]) begin
				div_sd[k] <= nxt;
			end
		end
	end

	// ------------------------------------------------------------------
	// output stage: start point plus signed step, zero without a hit
	// ------------------------------------------------------------------
	sit_pkg::div_t    fin;
	logic [W:0]       sum_x, sum_y;
	logic [W-1:0]     cross_x_s, cross_y_s;
	logic             hit_out_s;

	assign fin = div_sd[DS-1];

	always_comb begin
		sum_x = fin.neg_x ? ({fin.base_x[W-1], fin.base_x} - {1'b0, fin.quo_x})
			: ({fin.base_x[W-1], fin.base_x} + {1'b0, fin.quo_x});
		sum_y = fin.neg_y ? ({fin.base_y[W-1], fin.base_y} - {1'b0, fin.quo_y})
			: ({fin.base_y[W-1], fin.base_y} + {1'b0, fin.quo_y});
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			hit_out_s <= fin.hit;
			cross_x_s <= fin.hit ? sum_x[W-1:0] : '0;
			cross_y_s <= fin.hit ? sum_y[W-1:0] : '0;
		end
	end

	assign m_tdata = sit_pkg::OUT_DATA_W'({cross_y_s, cross_x_s});
	assign m_tuser = hit_out_s;

endmodule

`default_nettype wire

// ----- sim/segment_intersection_checker.sv -----
// ----------------------------------------------------------------------------
// segment_intersection_checker: result predictor and scoreboard
// Watches both stream channels of the segment intersection block. Every pair
// accepted on the input is run through an exact integer predictor, and the
// expected hit flag and crossing point are queued. Every result accepted on
// the output is compared field by field with the oldest queued expectation.
// ----------------------------------------------------------------------------
module segment_intersection_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [sit_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [sit_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           m_tuser,
	output int                             pending,
	output int                             fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = sit_pkg::COORD_WIDTH;

	// input transfer, first field in the lowest bits
	typedef struct packed {
		logic signed [W-1:0] b_end_y;
		logic signed [W-1:0] b_end_x;
		logic signed [W-1:0] b_start_y;
		logic signed [W-1:0] b_start_x;
		logic signed [W-1:0] a_end_y;
		logic signed [W-1:0] a_end_x;
		logic signed [W-1:0] a_start_y;
		logic signed [W-1:0] a_start_x;
	} seg_pair_t;

	typedef struct packed {
		logic                hit;
		logic signed [W-1:0] cross_y;
		logic signed [W-1:0] cross_x;
	} crossing_t;

	crossing_t crossing_q[$];
	int        mismatches = 0;

	initial begin
		pending    = 0;
		fail_count = 0;
	end

	// base + trunc(tn * delta / den); tn <= den keeps the step within |delta|
	function automatic logic [W-1:0] step_along(longint base, longint delta,
			longint tn, longint den);
		longint mag;
		longint step;
		mag  = (delta < 0) ? -delta : delta;
		step = (tn * mag) / den;
		return W'((delta < 0) ? base - step : base + step);
	endfunction

	function automatic crossing_t predict_crossing(seg_pair_t p);
		longint    rx, ry, qx, qy, wx, wy;
		longint    den, sn, tn;
		crossing_t c;
		rx  = longint'(p.a_end_x) - longint'(p.a_start_x);
		ry  = longint'(p.a_end_y) - longint'(p.a_start_y);
		qx  = longint'(p.b_end_x) - longint'(p.b_start_x);
		qy  = longint'(p.b_end_y) - longint'(p.b_start_y);
		wx  = longint'(p.a_start_x) - longint'(p.b_start_x);
		wy  = longint'(p.a_start_y) - longint'(p.b_start_y);
		den = rx * qy - qx * ry;
		sn  = rx * wy - ry * wx;
		tn  = qx * wy - qy * wx;
		// normalize so that den is positive
		if (den < 0) begin
			den = -den;
			sn  = -sn;
			tn  = -tn;
		end
		c = '0;
		c.hit = (den != 0) && (sn >= 0) && (sn <= den) && (tn >= 0) && (tn <= den);
		if (c.hit) begin
			c.cross_x = step_along(longint'(p.a_start_x), rx, tn, den);
			c.cross_y = step_along(longint'(p.a_start_y), ry, tn, den);
		end
		return c;
	endfunction

	// sample both channels at the clock edge, outside reset
	always @(posedge clk) begin
		crossing_t exp_c;
		crossing_t got_c;
		if (arst_n && s_tvalid && s_tready)
			crossing_q.push_back(predict_crossing(seg_pair_t'(s_tdata)));
		if (arst_n && m_tvalid && m_tready) begin
			got_c.hit     = m_tuser;
			got_c.cross_x = m_tdata[W-1:0];
			got_c.cross_y = m_tdata[2*W-1:W];
			if (crossing_q.size() == 0) begin
				$error("result with none expected: hit %0b x %0d y %0d",
					got_c.hit, got_c.cross_x, got_c.cross_y);
				mismatches++;
			end else begin
				exp_c = crossing_q.pop_front();
				if (got_c.hit !== exp_c.hit) begin
					$error("hit: expected %0b, got %0b", exp_c.hit, got_c.hit);
					mismatches++;
				end
				if (got_c.cross_x !== exp_c.cross_x) begin
					$error("cross_x: expected %0d, got %0d", exp_c.cross_x, got_c.cross_x);
					mismatches++;
				end
				if (got_c.cross_y !== exp_c.cross_y) begin
					$error("cross_y: expected %0d, got %0d", exp_c.cross_y, got_c.cross_y);
					mismatches++;
				end
			end
		end
		pending    <= crossing_q.size();
		fail_count <= mismatches;
	end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the segment intersection block
// Drives directed segment pairs (crossings, touching ends, parallel,
// collinear and degenerate segments, full-range coordinates), then random
// pairs in four phases of sender gaps and receiver stalls. A separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W          = sit_pkg::COORD_WIDTH;
	localparam int PHASE_LEN  = 200;
	localparam int QUIET_MAX  = 5000;
	localparam int TAIL_WAIT  = sit_pkg::NUM_STAGES + 8;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [sit_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [sit_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           m_tuser;

	int pending;
	int fail_count;
	int send_idle  = 0;
	int recv_stall = 0;
	int quiet_cycles = 0;

	segment_intersection_test dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	segment_intersection_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall);

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("segment_intersection_test test failed");
			$finish;
		end
	end

	// uniform value in [-span, span]
	function automatic int spread(int span);
		int v;
		v = $urandom_range(2 * span);
		return v - span;
	endfunction

	// one coordinate from the corners of the range, or anything
	function automatic int corner_coord();
		case ($urandom_range(5))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			4: return 1;
			default: return $urandom_range(65535);
		endcase
	endfunction

	// present one pair, with random gaps ahead of it, until it is taken
	task automatic send_pair(input int ax0, ay0, ax1, ay1,
			bx0, by0, bx1, by1);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {W'(by1), W'(bx1), W'(by0), W'(bx0),
			W'(ay1), W'(ax1), W'(ay0), W'(ax0)};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// hold off the sender until every expected result is out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send_random_pair();
		int c[8];
		int sel;
		int k;
		int m;
		sel = $urandom_range(99);
		if (sel < 25) begin
			// anything at all
			foreach (c[i])
				c[i] = $urandom_range(65535);
		end else if (sel < 55) begin
			// both segments in a small box: frequent hits and exact end touches
			c[0] = spread(30000);
			c[1] = spread(30000);
			for (int i = 2; i < 8; i++)
				c[i] = c[i % 2] + spread(8);
			c[0] = c[0] + spread(8);
			c[1] = c[1] + spread(8);
		end else if (sel < 65) begin
			// parallel or collinear
			c[0] = spread(1000);
			c[1] = spread(1000);
			c[2] = c[0] + spread(200);
			c[3] = c[1] + spread(200);
			k = $urandom_range(2) + 1;
			if ($urandom_range(1)) begin
				m = spread(2);
				c[4] = c[0] + m * (c[2] - c[0]) / 2;
				c[5] = c[1] + m * (c[3] - c[1]) / 2;
			end else begin
				c[4] = c[0] + spread(50);
				c[5] = c[1] + spread(50);
			end
			if ($urandom_range(1))
				k = -k;
			c[6] = c[4] + k * (c[2] - c[0]);
			c[7] = c[5] + k * (c[3] - c[1]);
		end else if (sel < 80) begin
			// B starts or ends on an end of A
			for (int i = 0; i < 8; i++)
				c[i] = spread(16000);
			k = $urandom_range(1) * 2;
			m = $urandom_range(1) * 2 + 4;
			c[m]     = c[k];
			c[m + 1] = c[k + 1];
		end else if (sel < 85) begin
			// a point instead of a segment
			foreach (c[i])
				c[i] = $urandom_range(65535);
			k = $urandom_range(1) * 4;
			c[k + 2] = c[k];
			c[k + 3] = c[k + 1];
		end else begin
			foreach (c[i])
				c[i] = corner_coord();
		end
		send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pairs
		send_pair(-100, -100, 100, 100, -100, 100, 100, -100);
		send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		send_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
		send_pair(0, 0, 7, 3, 0, 3, 7, 0);
		send_pair(7, 3, 0, 0, 0, 3, 7, 0);
		send_pair(7, 3, 0, 0, 7, 0, 0, 3);
		send_pair(0, 0, 10, 10, 0, 1, 10, 11);
		send_pair(0, 0, 10, 0, 5, 0, 15, 0);
		send_pair(5, 5, 5, 5, 0, 0, 10, 10);
		send_pair(3, 3, 3, 3, 3, 3, 3, 3);
		send_pair(0, 0, 10, 0, 10, 0, 10, 10);
		send_pair(0, 0, 10, 0, 0, -5, 0, 5);
		send_pair(0, 0, 10, 0, 11, -5, 11, 5);
		send_pair(0, 0, 1, 1, 5, 0, 4, 1);
		send_pair(0, 0, 0, 0, 0, 0, 0, 0);
		send_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		send_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
		send_pair(-32768, 32767, 32767, -32767, 32767, 32767, -32768, -32768);
		drain_results();

		// random phases: no idling, sender gaps, receiver stalls, both
		for (int phase = 0; phase < 4; phase++) begin
			send_idle  = (phase == 1) ? 56 : (phase == 3) ? 28 : 0;
			recv_stall = (phase == 2) ? 56 : (phase == 3) ? 28 : 0;
			for (int n = 0; n < PHASE_LEN; n++)
				send_random_pair();
			if (phase == 1)
				drain_results();
		end

		// wait out the pipeline
		drain_results();
		repeat (TAIL_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("segment_intersection_test test passed");
		else
			$display("segment_intersection_test test failed");
		$finish;
	end

endmodule
